@@ design/x86_alu_shift_lazy_flags_defines.svh @@
// Assertion macros for the x86 ALU/shifter block.
// Included by the top level; no other dependencies.
`ifndef X86_ALU_SHIFT_LAZY_FLAGS_DEFINES_SVH
`define X86_ALU_SHIFT_LAZY_FLAGS_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ design/xalu_pkg.sv @@
// Shared types and codes for the x86 ALU/shifter block.
// No dependencies.
package xalu_pkg;
  typedef enum logic [3:0] {
    LK_NONE = 4'd0, LK_ADD = 4'd1, LK_BIT = 4'd2, LK_ADC = 4'd3, LK_SBB = 4'd4,
    LK_SUB = 4'd5, LK_SHL = 4'd6, LK_SHR = 4'd7, LK_SAR = 4'd8
  } lazy_kind_t;

  localparam logic [2:0] OP_ADD = 3'd0, OP_OR = 3'd1, OP_ADC = 3'd2, OP_SBB = 3'd3;
  localparam logic [2:0] OP_AND = 3'd4, OP_SUB = 3'd5, OP_XOR = 3'd6;
  localparam logic [2:0] OP_ROL = 3'd0, OP_ROR = 3'd1, OP_RCL = 3'd2, OP_RCR = 3'd3;
  localparam logic [2:0] OP_SHL = 3'd4, OP_SHR = 3'd5, OP_SAL = 3'd6, OP_SAR = 3'd7;
  localparam logic [1:0] WS_8 = 2'd0, WS_16 = 2'd1;

  // stage 1 -> stage 2
  typedef struct packed {
    logic        action;
    logic [2:0]  op;
    logic [1:0]  ws;
    logic [31:0] d;
    logic [31:0] s;
    logic        cin;
    logic        s_nz;
    logic [4:0]  c;
    logic [5:0]  n;     // rotate amount (mod w or mod w+1)
  } s1_t;

  typedef struct packed {
    logic [31:0] res;
    logic        wr;
    logic        dir;
    logic        co;
    logic        ov;
    lazy_kind_t  kind;
    logic        w1;
    logic [31:0] op1;
    logic        w2;
    logic [31:0] op2;
    logic [1:0]  ws;
  } s2_t;

  function automatic logic [31:0] sext(input logic [31:0] v, input logic [1:0] ws);
    logic [31:0] r;
    case (ws)
      WS_8:    r = {{24{v[7]}}, v[7:0]};
      WS_16:   r = {{16{v[15]}}, v[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction
endpackage

@@ design/x86_alu_shift_lazy_flags.sv @@
// x86 ALU/shifter top level: three-stage pipeline ending in an output register.
// Depends on xalu_pkg and x86_alu_shift_lazy_flags_defines.svh.
// One operation per cycle while the output is not stalled.
// Stage 1 masks operands to the width and reduces the shift/rotate count
// (mod w, or mod w+1 for rotate-through-carry, via a small compare/subtract).
// Stage 2 runs the adder or the 64-bit shifter and forms flags and the lazy
// record. Stage 3 sign-extends the lazy result and holds it for the consumer.
// A stall freezes all stages together; in_tready is high whenever the output
// register is empty or being drained.
`include "x86_alu_shift_lazy_flags_defines.svh"
module x86_alu_shift_lazy_flags
  import xalu_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] dest_value, [63:32] source_value, [64] carry_in, rest zero
  input  logic [71:0]  in_tdata,
  // [0] action, [3:1] op_code, [5:4] width_sel
  input  logic [5:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] new_dest, [32] dest_written, [33] direct_flags, [34] carry_out,
  // [35] overflow_out, [39:36] lazy_kind, [40] lazy_op1_written, [72:41] lazy_op1,
  // [73] lazy_op2_written, [105:74] lazy_op2, [137:106] lazy_result, rest zero
  output logic [143:0] out_tdata
);
  logic adv;
  logic v1_r, v2_r, v3_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  logic [137:0] o_r, o_nxt;

  assign adv        = !v3_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = v3_r;
  assign out_tdata  = {6'd0, o_r};

  // stage 1: masking and count reduction
  always_comb begin
    logic [31:0] mask;
    logic [5:0]  m;
    logic [5:0]  w1p;
    mask = (in_tuser[5:4] == WS_8) ? 32'hFF :
           (in_tuser[5:4] == WS_16) ? 32'hFFFF : 32'hFFFF_FFFF;
    s1_nxt.action = in_tuser[0];
    s1_nxt.op     = in_tuser[3:1];
    s1_nxt.ws     = in_tuser[5:4];
    s1_nxt.d      = in_tdata[31:0] & mask;
    s1_nxt.s      = in_tdata[63:32] & mask;
    s1_nxt.cin    = in_tdata[64];
    s1_nxt.s_nz   = s1_nxt.s != 32'd0;
    s1_nxt.c      = s1_nxt.s[4:0];
    w1p = (s1_nxt.ws == WS_8) ? 6'd9 : (s1_nxt.ws == WS_16) ? 6'd17 : 6'd33;
    m = {1'b0, s1_nxt.c};
    if (s1_nxt.op == OP_RCL || s1_nxt.op == OP_RCR) begin
      if (m >= w1p) m = m - w1p;
      if (m >= w1p) m = m - w1p;
      if (m >= w1p) m = m - w1p;
    end else begin
      m = (s1_nxt.ws == WS_8) ? {3'd0, m[2:0]} :
          (s1_nxt.ws == WS_16) ? {2'd0, m[3:0]} : m;
    end
    s1_nxt.n = m;
  end

  // stage 2: operation
  always_comb begin
    logic [31:0] d, s, res, mask, sd;
    logic [5:0]  w, n;
    logic [4:0]  wt, wt2;   // top bit index and the one below it
    logic [63:0] x, r64;
    logic [32:0] sum;
    logic [4:0]  c;
    d = s1_r.d; s = s1_r.s; n = s1_r.n; c = s1_r.c;
    w = (s1_r.ws == WS_8) ? 6'd8 : (s1_r.ws == WS_16) ? 6'd16 : 6'd32;
    wt  = w[4:0] - 5'd1;
    wt2 = w[4:0] - 5'd2;
    mask = (s1_r.ws == WS_8) ? 32'hFF : (s1_r.ws == WS_16) ? 32'hFFFF : 32'hFFFF_FFFF;
    x = {32'd0, d};
    sd = sext(d, s1_r.ws);
    res = d;
    sum = 33'd0;
    r64 = 64'd0;
    s2_nxt = '0;
    s2_nxt.ws = s1_r.ws;
    s2_nxt.kind = LK_NONE;
    if (!s1_r.action) begin
      case (s1_r.op)
        OP_ADD: begin
          sum = {1'b0, d} + {1'b0, s}; res = sum[31:0] & mask;
          s2_nxt.w2 = 1'b1; s2_nxt.op2 = s; s2_nxt.kind = LK_ADD;
        end
        OP_OR: begin res = d | s; s2_nxt.kind = LK_BIT; end
        OP_ADC: begin
          sum = {1'b0, d} + {1'b0, s} + {32'd0, s1_r.cin}; res = sum[31:0] & mask;
          s2_nxt.w1 = 1'b1; s2_nxt.op1 = d; s2_nxt.w2 = 1'b1; s2_nxt.op2 = s;
          s2_nxt.kind = LK_ADC;
        end
        OP_SBB: begin
          sum = {1'b0, d} - {1'b0, s} - {32'd0, s1_r.cin}; res = sum[31:0] & mask;
          s2_nxt.w1 = 1'b1; s2_nxt.op1 = d; s2_nxt.w2 = 1'b1; s2_nxt.op2 = s;
          s2_nxt.kind = LK_SBB;
        end
        OP_AND: begin res = d & s; s2_nxt.kind = LK_BIT; end
        OP_SUB: begin
          sum = {1'b0, d} - {1'b0, s}; res = sum[31:0] & mask;
          s2_nxt.w2 = 1'b1; s2_nxt.op2 = s; s2_nxt.kind = LK_SUB;
        end
        OP_XOR: begin res = d ^ s; s2_nxt.kind = LK_BIT; end
        default: ;
      endcase
      s2_nxt.wr = s2_nxt.kind != LK_NONE;
    end else if (s1_r.s_nz) begin
      s2_nxt.wr = 1'b1;
      case (s1_r.op)
        OP_ROL: begin
          if (n != 6'd0) begin
            r64 = (x << n) | (x >> (w - n)); res = r64[31:0] & mask;
          end
          if (c != 5'd0) begin
            s2_nxt.dir = 1'b1; s2_nxt.co = res[0];
            s2_nxt.ov = res[0] ^ res[wt];
          end
        end
        OP_ROR: begin
          if (n != 6'd0) begin
            r64 = (x >> n) | (x << (w - n)); res = r64[31:0] & mask;
          end
          if (c != 5'd0) begin
            s2_nxt.dir = 1'b1; s2_nxt.co = res[wt];
            s2_nxt.ov = res[wt] ^ res[wt2];
          end
        end
        OP_RCL: begin
          if (n != 6'd0) begin
            r64 = (x << n) | ({63'd0, s1_r.cin} << (n - 6'd1)) | (x >> (w + 6'd1 - n));
            res = r64[31:0] & mask;
            s2_nxt.co = x[w - n]; s2_nxt.ov = s2_nxt.co ^ res[wt];
            s2_nxt.dir = 1'b1;
          end
        end
        OP_RCR: begin
          if (n != 6'd0) begin
            r64 = (x >> n) | ({63'd0, s1_r.cin} << (w - n)) | (x << (w + 6'd1 - n));
            res = r64[31:0] & mask;
            s2_nxt.co = x[n - 6'd1];
            s2_nxt.ov = res[wt] ^ res[wt2];
            s2_nxt.dir = 1'b1;
          end
        end
        OP_SHL, OP_SAL, OP_SHR, OP_SAR: begin
          if (c != 5'd0) begin
            s2_nxt.w1 = 1'b1; s2_nxt.w2 = 1'b1; s2_nxt.op2 = {27'd0, c};
            if (s1_r.op == OP_SHR) begin
              res = d >> c; s2_nxt.op1 = d; s2_nxt.kind = LK_SHR;
            end else if (s1_r.op == OP_SAR) begin
              res = 32'($signed(sd) >>> c) & mask; s2_nxt.op1 = sd;
              s2_nxt.kind = LK_SAR;
            end else begin
              res = (d << c) & mask; s2_nxt.op1 = d; s2_nxt.kind = LK_SHL;
            end
          end
        end
        default: ;
      endcase
    end
    s2_nxt.res = res;
  end

  // stage 3: lazy result sign extension and packing
  always_comb begin
    o_nxt = {(s2_r.kind != LK_NONE) ? sext(s2_r.res, s2_r.ws) : 32'd0,
             s2_r.op2, s2_r.w2, s2_r.op1, s2_r.w1, s2_r.kind,
             s2_r.ov, s2_r.co, s2_r.dir, s2_r.wr, s2_r.res};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid; v2_r <= v1_r; v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt; s2_r <= s2_nxt; o_r <= o_nxt;
    end
  end

  `ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `ASSERT_IMPLIES(a_ready, !out_tvalid, in_tready, "not ready with empty output")
  `ASSERT_IMPLIES(a_lazy_zero, out_tvalid && out_tdata[39:36] == LK_NONE, out_tdata[137:106] == 32'd0, "lazy result without kind")
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the x86 ALU/shifter with lazy flags.
// Depends on xalu_pkg and the x86_alu_shift_lazy_flags top level.
import xalu_pkg::*;

// Expected result of one request; field order follows out_tdata from the top bit down.
typedef struct packed {
  logic [31:0] lazy_result;
  logic [31:0] lazy_op2;
  logic        lazy_op2_written;
  logic [31:0] lazy_op1;
  logic        lazy_op1_written;
  logic [3:0]  lazy_kind;
  logic        overflow_out;
  logic        carry_out;
  logic        direct_flags;
  logic        dest_written;
  logic [31:0] new_dest;
} alu_result_t;

class alu_scoreboard;
  alu_result_t pending_results[$];
  int errors;

  function logic [31:0] sign_extend(logic [31:0] v, int unsigned w);
    logic [31:0] r;
    r = v;
    if (w == 8) r = {{24{v[7]}}, v[7:0]};
    else if (w == 16) r = {{16{v[15]}}, v[15:0]};
    return r;
  endfunction

  // Predict the outcome of one request.
  function void note_request(logic action, logic [2:0] op, logic [1:0] ws,
                             logic [31:0] dv, logic [31:0] sv, logic cin);
    alu_result_t e;
    int unsigned w, n, c;
    logic [31:0] mask, d, s, sd;
    logic [63:0] x, r64;
    lazy_kind_t kind;
    w = (ws == WS_8) ? 8 : (ws == WS_16) ? 16 : 32;
    mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
    d = dv & mask;
    s = sv & mask;
    x = {32'd0, d};
    e = '0;
    e.new_dest = d;
    kind = LK_NONE;
    c = s[4:0];
    if (!action) begin
      case (op)
        OP_ADD: begin
          e.new_dest = (d + s) & mask; e.lazy_op2_written = 1; e.lazy_op2 = s; kind = LK_ADD;
        end
        OP_OR: begin e.new_dest = d | s; kind = LK_BIT; end
        OP_ADC: begin
          e.new_dest = (d + s + cin) & mask; e.lazy_op1_written = 1; e.lazy_op1 = d;
          e.lazy_op2_written = 1; e.lazy_op2 = s; kind = LK_ADC;
        end
        OP_SBB: begin
          e.new_dest = (d - (s + cin)) & mask; e.lazy_op1_written = 1; e.lazy_op1 = d;
          e.lazy_op2_written = 1; e.lazy_op2 = s; kind = LK_SBB;
        end
        OP_AND: begin e.new_dest = d & s; kind = LK_BIT; end
        OP_SUB: begin
          e.new_dest = (d - s) & mask; e.lazy_op2_written = 1; e.lazy_op2 = s; kind = LK_SUB;
        end
        OP_XOR: begin e.new_dest = d ^ s; kind = LK_BIT; end
        default: ;
      endcase
      e.dest_written = (kind != LK_NONE);
    end else if (s != 0) begin
      e.dest_written = 1;
      case (op)
        OP_ROL: begin
          n = s & (w - 1);
          if (n != 0) e.new_dest = ((d << n) | (d >> (w - n))) & mask;
          if (c != 0) begin
            e.direct_flags = 1;
            e.carry_out = e.new_dest[0];
            e.overflow_out = e.new_dest[0] ^ e.new_dest[w-1];
          end
        end
        OP_ROR: begin
          n = s & (w - 1);
          if (n != 0) e.new_dest = ((d >> n) | (d << (w - n))) & mask;
          if (c != 0) begin
            e.direct_flags = 1;
            e.carry_out = e.new_dest[w-1];
            e.overflow_out = e.new_dest[w-1] ^ e.new_dest[w-2];
          end
        end
        OP_RCL: begin
          n = c % (w + 1);
          if (n != 0) begin
            r64 = (x << n) | (64'(cin) << (n - 1)) | (x >> (w + 1 - n));
            e.new_dest = r64[31:0] & mask;
            e.carry_out = d[w-n];
            e.overflow_out = e.carry_out ^ e.new_dest[w-1];
            e.direct_flags = 1;
          end
        end
        OP_RCR: begin
          n = c % (w + 1);
          if (n != 0) begin
            r64 = (x >> n) | (64'(cin) << (w - n)) | (x << (w + 1 - n));
            e.new_dest = r64[31:0] & mask;
            e.carry_out = d[n-1];
            e.overflow_out = e.new_dest[w-1] ^ e.new_dest[w-2];
            e.direct_flags = 1;
          end
        end
        OP_SHL, OP_SAL: if (c != 0) begin
          e.new_dest = 32'((x << c) & {32'd0, mask}); kind = LK_SHL;
          e.lazy_op1_written = 1; e.lazy_op1 = d; e.lazy_op2_written = 1; e.lazy_op2 = c;
        end
        OP_SHR: if (c != 0) begin
          e.new_dest = d >> c; kind = LK_SHR;
          e.lazy_op1_written = 1; e.lazy_op1 = d; e.lazy_op2_written = 1; e.lazy_op2 = c;
        end
        default: if (c != 0) begin
          sd = sign_extend(d, w);
          e.new_dest = 32'($signed(sd) >>> c) & mask; kind = LK_SAR;
          e.lazy_op1_written = 1; e.lazy_op1 = sd; e.lazy_op2_written = 1; e.lazy_op2 = c;
        end
      endcase
    end
    e.lazy_kind = kind;
    if (kind != LK_NONE) e.lazy_result = sign_extend(e.new_dest, w);
    pending_results.push_back(e);
  endfunction

  function void check_result(logic [143:0] data);
    alu_result_t got, exp_r;
    got = data[137:0];
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, data);
      errors++;
      return;
    end
    exp_r = pending_results.pop_front();
    if (data[143:138] != 0) begin
      $display("%0t: pad bits expected 0 actual %h", $time, data[143:138]);
      errors++;
    end
    if (got.new_dest != exp_r.new_dest) begin
      $display("%0t: new_dest expected %h actual %h", $time, exp_r.new_dest, got.new_dest);
      errors++;
    end
    if (got.dest_written != exp_r.dest_written) begin
      $display("%0t: dest_written expected %b actual %b", $time,
               exp_r.dest_written, got.dest_written);
      errors++;
    end
    if (got.direct_flags != exp_r.direct_flags) begin
      $display("%0t: direct_flags expected %b actual %b", $time,
               exp_r.direct_flags, got.direct_flags);
      errors++;
    end
    if (got.carry_out != exp_r.carry_out) begin
      $display("%0t: carry_out expected %b actual %b", $time, exp_r.carry_out, got.carry_out);
      errors++;
    end
    if (got.overflow_out != exp_r.overflow_out) begin
      $display("%0t: overflow_out expected %b actual %b", $time,
               exp_r.overflow_out, got.overflow_out);
      errors++;
    end
    if (got.lazy_kind != exp_r.lazy_kind) begin
      $display("%0t: lazy_kind expected %0d actual %0d", $time, exp_r.lazy_kind, got.lazy_kind);
      errors++;
    end
    if (got.lazy_op1_written != exp_r.lazy_op1_written) begin
      $display("%0t: lazy_op1_written expected %b actual %b", $time,
               exp_r.lazy_op1_written, got.lazy_op1_written);
      errors++;
    end
    if (got.lazy_op1 != exp_r.lazy_op1) begin
      $display("%0t: lazy_op1 expected %h actual %h", $time, exp_r.lazy_op1, got.lazy_op1);
      errors++;
    end
    if (got.lazy_op2_written != exp_r.lazy_op2_written) begin
      $display("%0t: lazy_op2_written expected %b actual %b", $time,
               exp_r.lazy_op2_written, got.lazy_op2_written);
      errors++;
    end
    if (got.lazy_op2 != exp_r.lazy_op2) begin
      $display("%0t: lazy_op2 expected %h actual %h", $time, exp_r.lazy_op2, got.lazy_op2);
      errors++;
    end
    if (got.lazy_result != exp_r.lazy_result) begin
      $display("%0t: lazy_result expected %h actual %h", $time,
               exp_r.lazy_result, got.lazy_result);
      errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int RANDOM_REQUESTS = 1830;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 10;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [71:0]  in_tdata = '0;
  logic [5:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;

  alu_scoreboard alu_sb = new();
  int  cycle_count = 0;
  bit  steady_phase = 1'b0;  // no idling on either side while set

  x86_alu_shift_lazy_flags i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random backpressure, checked on each accepted result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) alu_sb.check_result(out_tdata);
    out_tready <= steady_phase || ($urandom_range(99) >= 7);
  end

  // Present one request and hold it until accepted; idle a cycle now and then.
  task automatic send_request(logic action, logic [2:0] op, logic [1:0] ws,
                              logic [31:0] dv, logic [31:0] sv, logic cin);
    if (!steady_phase && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {ws, op, action};
    in_tdata  <= {7'd0, cin, sv, dv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    alu_sb.note_request(action, op, ws, dv, sv, cin);
  endtask

  // Counts biased toward the interesting boundaries (0, width, width+1, 31, 32).
  function automatic logic [31:0] pick_count();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom_range(33);
      1: v = 32'(8 * $urandom_range(1, 4)) + $urandom_range(2) - 1;
      2: v = 32'({8'($urandom_range(255)), 3'd0, 5'($urandom_range(31))}
                 << $urandom_range(8));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0080 | 32'h0000_8000;
      3: return 32'h7F7F_7FFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic        action;
    logic [2:0]  op;
    logic [1:0]  ws;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every op in each group, field extremes, zero and wrap counts,
    // width code three, and the no-op arithmetic code.
    for (int o = 0; o < 8; o++) begin
      send_request(1'b0, 3'(o), 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(1'b1, 3'(o), 2'd1, 32'h0000_8001, 32'd17, 1'b1);
    end
    send_request(1'b1, OP_ROL, 2'd2, 32'h8000_0001, 32'd32, 1'b0); // nonzero, masked zero
    send_request(1'b1, OP_SHL, 2'd0, 32'h0000_00FF, 32'h100, 1'b1); // truncated to zero
    send_request(1'b1, OP_RCL, 2'd0, 32'h0000_0081, 32'd9, 1'b1);   // rcl count wraps
    send_request(1'b1, OP_RCR, 2'd2, 32'h8000_0001, 32'd31, 1'b1);
    send_request(1'b1, OP_SAR, 2'd0, 32'h0000_0080, 32'd31, 1'b0);
    send_request(1'b1, OP_ROR, 2'd0, 32'h0000_0001, 32'd8, 1'b0);  // rotate by width
    send_request(1'b0, OP_ADC, 2'd3, 32'hFFFF_FFFF, 32'h0, 1'b1);   // width code three
    send_request(1'b0, OP_SBB, 2'd1, 32'h0, 32'hFFFF, 1'b1);
    send_request(1'b1, OP_SHR, 2'd3, 32'hFFFF_FFFF, 32'd1, 1'b0);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady_phase = (i >= 600 && i < 900);
      action = 1'($urandom_range(1));
      op     = 3'($urandom_range(7));
      ws     = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      send_request(action, op, ws, pick_value(),
                   action ? pick_count() : pick_value(), 1'($urandom_range(1)));
    end
    in_tvalid <= 1'b0;
    steady_phase = 1'b0;

    while (alu_sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (alu_sb.errors == 0 && alu_sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
